// File: design/cdr_pkg.sv
// Shared types, constants and calendar functions for the calendar date register.
package cdr_pkg;

    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int IN_YEAR_W = 16;
    localparam int IN_STEP_W = 16;
    localparam int ACTION_W  = 2;

    localparam logic [ACTION_W-1:0] ACT_SET     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COMPARE = 2'd2;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTHS    = 4'd12;

    // Year is tracked modulo 400, enough to decide every leap rule.
    localparam int YEAR_MOD = 400;
    localparam int REM_W    = 9;

    localparam logic [REM_W-1:0] REM_LAST = REM_W'(YEAR_MOD - 1);
    localparam logic [REM_W-1:0] REM_C1   = REM_W'(100);
    localparam logic [REM_W-1:0] REM_C2   = REM_W'(200);
    localparam logic [REM_W-1:0] REM_C3   = REM_W'(300);

    typedef struct packed {
        logic             done;
        logic [REM_W-1:0] rem;
    } rem_status_t;

    function automatic logic is_leap(input logic [REM_W-1:0] r);
        return (r[1:0] == 2'b00) && (r != REM_C1) && (r != REM_C2) && (r != REM_C3);
    endfunction

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                       input logic leap);
        logic [DAY_W-1:0] n;
        n = 5'd31;
        if (m == MONTH_FEB) begin
            n = leap ? 5'd29 : 5'd28;
        end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            n = 5'd30;
        end
        return n;
    endfunction

endpackage

// File: design/calendar_date_register.sv
// Calendar date register: holds one Gregorian date; set, advance by days and compare.
// One item at a time. A compare, the unused action code, or an advance while the month
// is 0 passes through the DONE state to the output register. An advance from a valid
// date first subtracts one month length per cycle, a month boundary at a time, until
// the remaining days fit the month, then passes through DONE. A set waits while the
// year is reduced modulo 400 by a two-stage reciprocal multiply to find its leap
// status. The block is ready for the next item once a result is loaded into the
// output register; while that result waits, the next item is worked on and then
// held until the output register frees.
module calendar_date_register #(
    parameter int YEAR_BITS = 16,
    parameter int STEP_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cdr_pkg::ACTION_W-1:0]    s_action,
    input  logic [cdr_pkg::DAY_W-1:0]       s_in_day,
    input  logic [cdr_pkg::MONTH_W-1:0]     s_in_month,
    input  logic [cdr_pkg::IN_YEAR_W-1:0]   s_in_year,
    input  logic [cdr_pkg::IN_STEP_W-1:0]   s_days_to_add,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cdr_pkg::DAY_W-1:0]       m_cur_day,
    output logic [cdr_pkg::MONTH_W-1:0]     m_cur_month,
    output logic [cdr_pkg::IN_YEAR_W-1:0]   m_cur_year,
    output logic                            m_is_default_date,
    output logic                            m_dates_equal,
    output logic                            m_stored_earlier
);
    import cdr_pkg::*;

    localparam int N_W   = (STEP_BITS < IN_STEP_W) ? STEP_BITS : IN_STEP_W;
    localparam int ACC_W = N_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SET  = 2'd1;
    localparam logic [1:0] ST_ADV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [DAY_W-1:0]     day_reg, day_next;
    logic [MONTH_W-1:0]   month_reg, month_next;
    logic [YEAR_BITS-1:0] year_reg, year_next;
    logic [REM_W-1:0]     r400_reg, r400_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [DAY_W-1:0]     set_day_reg, set_day_next;
    logic [MONTH_W-1:0]   set_month_reg, set_month_next;
    logic [YEAR_BITS-1:0] set_year_reg, set_year_next;
    logic                 eq_reg, eq_next;
    logic                 lt_reg, lt_next;

    logic                 out_valid_reg, out_valid_next;
    logic [DAY_W-1:0]     out_day_reg;
    logic [MONTH_W-1:0]   out_month_reg;
    logic [IN_YEAR_W-1:0] out_year_reg;
    logic                 out_def_reg, out_eq_reg, out_lt_reg;

    logic                 accept, out_free, rem_start;
    logic [YEAR_BITS-1:0] given_year;
    logic [DAY_W-1:0]     adv_len, set_len;
    rem_status_t          rem_st;

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign out_free   = !out_valid_reg || m_ready;
    assign given_year = YEAR_BITS'(s_in_year);
    assign rem_start  = accept && (s_action == ACT_SET);
    assign adv_len    = days_in_month(month_reg, is_leap(r400_reg));
    assign set_len    = days_in_month(set_month_reg, is_leap(rem_st.rem));

    cdr_rem400 #(
        .YEAR_BITS (YEAR_BITS)
    ) u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rem_start),
        .value   (given_year),
        .status  (rem_st)
    );

    always_comb begin
        state_next     = state_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        r400_next      = r400_reg;
        acc_next       = acc_reg;
        set_day_next   = set_day_reg;
        set_month_next = set_month_reg;
        set_year_next  = set_year_reg;
        eq_next        = eq_reg;
        lt_next        = lt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    eq_next    = 1'b0;
                    lt_next    = 1'b0;
                    state_next = ST_DONE;
                    case (s_action)
                        ACT_SET: begin
                            set_day_next   = s_in_day;
                            set_month_next = (s_in_month == '0 || s_in_month > MONTHS)
                                             ? MONTH_JAN : s_in_month;
                            set_year_next  = given_year;
                            state_next     = ST_SET;
                        end
                        ACT_ADVANCE: begin
                            acc_next = ACC_W'(day_reg) + ACC_W'(s_days_to_add[N_W-1:0]);
                            if (month_reg != '0 && month_reg <= MONTHS) begin
                                state_next = ST_ADV;
                            end
                        end
                        ACT_COMPARE: begin
                            eq_next = (day_reg == s_in_day) && (month_reg == s_in_month)
                                      && (year_reg == given_year);
                            if (year_reg != given_year) begin
                                lt_next = year_reg < given_year;
                            end else if (month_reg != s_in_month) begin
                                lt_next = month_reg < s_in_month;
                            end else begin
                                lt_next = day_reg < s_in_day;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SET: begin
                if (rem_st.done) begin
                    day_next   = (set_day_reg > set_len) ? DAY_W'(1) : set_day_reg;
                    month_next = set_month_reg;
                    year_next  = set_year_reg;
                    r400_next  = rem_st.rem;
                    state_next = ST_DONE;
                end
            end
            ST_ADV: begin
                if (acc_reg > ACC_W'(adv_len)) begin
                    acc_next = acc_reg - ACC_W'(adv_len);
                    if (month_reg == MONTHS) begin
                        month_next = MONTH_JAN;
                        year_next  = year_reg + 1'b1;
                        r400_next  = (&year_reg || r400_reg == REM_LAST)
                                     ? '0 : r400_reg + 1'b1;
                    end else begin
                        month_next = month_reg + 1'b1;
                    end
                end else begin
                    day_next   = acc_reg[DAY_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            day_reg       <= '0;
            month_reg     <= '0;
            year_reg      <= '0;
            r400_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            r400_reg      <= r400_next;
        end
        acc_reg       <= acc_next;
        set_day_reg   <= set_day_next;
        set_month_reg <= set_month_next;
        set_year_reg  <= set_year_next;
        eq_reg        <= eq_next;
        lt_reg        <= lt_next;
        if (state_reg == ST_DONE && out_free) begin
            out_day_reg   <= day_reg;
            out_month_reg <= month_reg;
            out_year_reg  <= IN_YEAR_W'(year_reg);
            out_def_reg   <= (day_reg == '0) && (month_reg == '0) && (year_reg == '0);
            out_eq_reg    <= eq_reg;
            out_lt_reg    <= lt_reg;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_cur_day         = out_day_reg;
    assign m_cur_month       = out_month_reg;
    assign m_cur_year        = out_year_reg;
    assign m_is_default_date = out_def_reg;
    assign m_dates_equal     = out_eq_reg;
    assign m_stored_earlier  = out_lt_reg;

endmodule

// File: design/cdr_rem400.sv
// Remainder of a year modulo 400 by a two-stage reciprocal multiply.
module cdr_rem400 #(
    parameter int YEAR_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [YEAR_BITS-1:0]  value,
    output cdr_pkg::rem_status_t  status
);
    import cdr_pkg::*;

    // year mod 400 = 16 * ((year >> 4) mod 25) + year[3:0]
    localparam int          X_W      = 28;
    localparam int          Q_W      = 24;
    localparam int          SHIFT    = 33;
    localparam logic [28:0] RECIP_25 = 29'd343597384;

    logic [X_W-1:0]   x_reg, x_next;
    logic [3:0]       lo_reg, lo_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic             p1_reg, p2_reg, done_reg;
    logic [X_W+28:0]  prod;
    logic [X_W-1:0]   q25;

    assign prod   = (X_W+29)'(x_reg) * (X_W+29)'(RECIP_25);
    assign q_next = Q_W'(prod >> SHIFT);
    assign q25    = X_W'(q_reg) * X_W'(25);

    always_comb begin
        x_next   = x_reg;
        lo_next  = lo_reg;
        rem_next = rem_reg;
        if (start) begin
            x_next  = X_W'(value[YEAR_BITS-1:4]);
            lo_next = value[3:0];
        end
        if (p2_reg) begin
            rem_next = {5'(x_reg - q25), lo_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg   <= 1'b0;
            p2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            p1_reg   <= start;
            p2_reg   <= p1_reg;
            done_reg <= p2_reg;
        end
        x_reg   <= x_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign status.done = done_reg;
    assign status.rem  = rem_reg;

endmodule

// File: design/cdr_checker.sv
// Port-level checker for the calendar date register, with its bind.
module cdr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [cdr_pkg::DAY_W-1:0]       m_cur_day,
    input logic [cdr_pkg::MONTH_W-1:0]     m_cur_month,
    input logic                            m_is_default_date,
    input logic                            m_dates_equal,
    input logic                            m_stored_earlier
);
    import cdr_pkg::*;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("block still ready right after taking an item");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cur_day) && $stable(m_cur_month))
        else $error("stalled result changed");

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_cur_month <= MONTHS)
        else $error("stored month out of range");

    a_default_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_default_date |-> m_cur_day == '0 && m_cur_month == '0)
        else $error("default flag with nonzero day or month");

    a_cmp_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dates_equal |-> !m_stored_earlier)
        else $error("equal and earlier both reported");

endmodule

bind calendar_date_register cdr_checker u_cdr_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for calendar_date_register: predicted dates vs. block results.
module testbench;
    import cdr_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam int RANDOM_ITEMS = 270;

    typedef struct packed {
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [IN_YEAR_W-1:0] year;
        logic                 dflt;
        logic                 eq;
        logic                 lt;
    } date_result_t;

    class date_scoreboard;
        logic [DAY_W-1:0]     day_q;
        logic [MONTH_W-1:0]   month_q;
        logic [IN_YEAR_W-1:0] year_q;
        date_result_t         pending_dates[$];
        int                   errors;

        function new();
            day_q = '0;
            month_q = '0;
            year_q = '0;
            errors = 0;
        endfunction

        function bit leap_year(logic [IN_YEAR_W-1:0] y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        function int unsigned month_length(logic [MONTH_W-1:0] m, logic [IN_YEAR_W-1:0] y);
            int unsigned len;
            case (m)
                4'd4, 4'd6, 4'd9, 4'd11: len = 30;
                MONTH_FEB: len = leap_year(y) ? 29 : 28;
                default: len = 31;
            endcase
            return len;
        endfunction

        function int pending();
            return pending_dates.size();
        endfunction

        function void note_input(logic [ACTION_W-1:0] act, logic [DAY_W-1:0] d,
                                 logic [MONTH_W-1:0] mo, logic [IN_YEAR_W-1:0] y,
                                 logic [IN_STEP_W-1:0] n);
            date_result_t r;
            int unsigned dd, len;
            logic [MONTH_W-1:0] mm;
            logic [IN_YEAR_W-1:0] yy;
            r.eq = 1'b0;
            r.lt = 1'b0;
            case (act)
                ACT_SET: begin
                    mm = (mo < MONTH_JAN || mo > MONTHS) ? MONTH_JAN : mo;
                    day_q = (d > month_length(mm, y)) ? 5'd1 : d;
                    month_q = mm;
                    year_q = y;
                end
                ACT_ADVANCE: begin
                    if (month_q >= MONTH_JAN && month_q <= MONTHS) begin
                        dd = day_q + n;
                        mm = month_q;
                        yy = year_q;
                        len = month_length(mm, yy);
                        while (dd > len) begin
                            dd -= len;
                            mm++;
                            if (mm > MONTHS) begin
                                mm = MONTH_JAN;
                                yy++;
                            end
                            len = month_length(mm, yy);
                        end
                        day_q = dd[DAY_W-1:0];
                        month_q = mm;
                        year_q = yy;
                    end
                end
                ACT_COMPARE: begin
                    r.eq = (day_q == d) && (month_q == mo) && (year_q == y);
                    if (year_q != y)
                        r.lt = year_q < y;
                    else if (month_q != mo)
                        r.lt = month_q < mo;
                    else
                        r.lt = day_q < d;
                end
                default: ;
            endcase
            r.day = day_q;
            r.month = month_q;
            r.year = year_q;
            r.dflt = (day_q == 0) && (month_q == 0) && (year_q == 0);
            pending_dates.push_back(r);
        endfunction

        function void check_result(date_result_t got);
            date_result_t want;
            if (pending_dates.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: %0d/%0d/%0d dflt=%0b eq=%0b lt=%0b",
                             got.day, got.month, got.year, got.dflt, got.eq, got.lt);
                return;
            end
            want = pending_dates.pop_front();
            if (got.day !== want.day || got.month !== want.month || got.year !== want.year ||
                got.dflt !== want.dflt || got.eq !== want.eq || got.lt !== want.lt) begin
                errors++;
                if (errors <= 10) begin
                    $write("mismatch: exp %0d/%0d/%0d dflt=%0b eq=%0b lt=%0b, ",
                           want.day, want.month, want.year, want.dflt, want.eq, want.lt);
                    $display("got %0d/%0d/%0d dflt=%0b eq=%0b lt=%0b",
                             got.day, got.month, got.year, got.dflt, got.eq, got.lt);
                end
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [ACTION_W-1:0]   s_action = '0;
    logic [DAY_W-1:0]      s_in_day = '0;
    logic [MONTH_W-1:0]    s_in_month = '0;
    logic [IN_YEAR_W-1:0]  s_in_year = '0;
    logic [IN_STEP_W-1:0]  s_days_to_add = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [DAY_W-1:0]      m_cur_day;
    logic [MONTH_W-1:0]    m_cur_month;
    logic [IN_YEAR_W-1:0]  m_cur_year;
    logic                  m_is_default_date;
    logic                  m_dates_equal;
    logic                  m_stored_earlier;

    logic                  hold_request = 1'b0;
    int                    sent = 0;
    date_scoreboard        sb = new();

    calendar_date_register uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_in_day          (s_in_day),
        .s_in_month        (s_in_month),
        .s_in_year         (s_in_year),
        .s_days_to_add     (s_days_to_add),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cur_day         (m_cur_day),
        .m_cur_month       (m_cur_month),
        .m_cur_year        (m_cur_year),
        .m_is_default_date (m_is_default_date),
        .m_dates_equal     (m_dates_equal),
        .m_stored_earlier  (m_stored_earlier)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_cur_day, m_cur_month, m_cur_year,
                             m_is_default_date, m_dates_equal, m_stored_earlier});
    end

    // Receiver: own stall pattern, plus one long hold-off on request.
    initial begin
        int unsigned cyc;
        bit          held;
        cyc = 0;
        held = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            cyc++;
            if (hold_request && !held) begin
                held = 1'b1;
                m_ready = 1'b0;
                repeat (400) @(negedge aclk);
            end
            case ((cyc / 50) % 4)
                0: m_ready = 1'b1;
                1: m_ready = ($urandom_range(1) == 0);
                2: m_ready = ($urandom_range(3) == 0);
                default: m_ready = cyc[0];
            endcase
        end
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_date_op(input logic [ACTION_W-1:0] act, input logic [DAY_W-1:0] d,
                                input logic [MONTH_W-1:0] mo, input logic [IN_YEAR_W-1:0] y,
                                input logic [IN_STEP_W-1:0] n);
        s_valid = 1'b1;
        s_action = act;
        s_in_day = d;
        s_in_month = mo;
        s_in_year = y;
        s_days_to_add = n;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(act, d, mo, y, n);
        sent++;
        @(negedge aclk);
    endtask

    task automatic sender_gap(input int cycles);
        if (cycles > 0) begin
            s_valid = 1'b0;
            repeat (cycles) @(negedge aclk);
        end
    endtask

    task automatic wait_all_results();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    function automatic logic [IN_YEAR_W-1:0] pick_year();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 50)
            return IN_YEAR_W'($urandom_range(1582, 2500));
        else if (k < 75)
            return IN_YEAR_W'($urandom);
        else if (k < 90)
            return IN_YEAR_W'($urandom_range(0, 163) * 400 + $urandom_range(0, 3) * 100);
        return IN_YEAR_W'(65535 - $urandom_range(0, 3));
    endfunction

    function automatic logic [IN_STEP_W-1:0] pick_step();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 60)
            return IN_STEP_W'($urandom_range(0, 400));
        else if (k < 85)
            return IN_STEP_W'($urandom_range(0, 4000));
        else if (k < 95)
            return IN_STEP_W'($urandom);
        return ($urandom_range(1) == 0) ? '0 : '1;
    endfunction

    task automatic send_random_item();
        logic [ACTION_W-1:0]  act;
        logic [DAY_W-1:0]     d;
        logic [MONTH_W-1:0]   mo;
        logic [IN_YEAR_W-1:0] y;
        logic [IN_STEP_W-1:0] n;
        int unsigned          k;
        k = $urandom_range(99);
        d = DAY_W'($urandom);
        mo = MONTH_W'($urandom);
        y = IN_YEAR_W'($urandom);
        n = IN_STEP_W'($urandom);
        if (k < 30) begin
            act = ACT_SET;
            if ($urandom_range(3) != 0) begin
                y = pick_year();
                mo = MONTH_W'($urandom_range(1, 12));
                if ($urandom_range(4) == 0)
                    mo = MONTH_FEB;
                d = DAY_W'($urandom_range(1, sb.month_length(mo, y)));
                if ($urandom_range(6) == 0)
                    d = DAY_W'($urandom_range(0, 31));
            end
        end else if (k < 65) begin
            act = ACT_ADVANCE;
            n = pick_step();
        end else if (k < 95) begin
            act = ACT_COMPARE;
            k = $urandom_range(9);
            if (k < 8) begin
                d = sb.day_q;
                mo = sb.month_q;
                y = sb.year_q;
                case (k)
                    4: d = d + (($urandom_range(1) == 0) ? 5'd1 : 5'h1f);
                    5: mo = mo + (($urandom_range(1) == 0) ? 4'd1 : 4'hf);
                    6: y = y + (($urandom_range(1) == 0) ? 16'd1 : 16'hffff);
                    7: y = y ^ IN_YEAR_W'(1 << $urandom_range(15));
                    default: ;
                endcase
            end
        end else begin
            act = ACT_NONE;
        end
        send_date_op(act, d, mo, y, n);
    endtask

    initial begin
        int burst;
        bit hold_done;
        bit drain_done;
        hold_done = 1'b0;
        drain_done = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // default date: advance is ignored, compare of zeros reports equal, idle code reports zeros
        send_date_op(ACT_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd100);
        send_date_op(ACT_COMPARE, 5'd0, 4'd0, 16'd0, 16'd0);
        send_date_op(ACT_NONE, 5'd31, 4'd15, 16'hffff, 16'hffff);
        // leap-day handling
        send_date_op(ACT_SET, 5'd29, MONTH_FEB, 16'd2000, 16'd0);
        send_date_op(ACT_SET, 5'd29, MONTH_FEB, 16'd1900, 16'd0);
        send_date_op(ACT_SET, 5'd29, MONTH_FEB, 16'd2024, 16'd0);
        send_date_op(ACT_SET, 5'd28, MONTH_FEB, 16'd2100, 16'd0);
        send_date_op(ACT_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd1);
        // day and month repair
        send_date_op(ACT_SET, 5'd31, 4'd4, 16'd2023, 16'd0);
        send_date_op(ACT_SET, 5'd0, 4'd5, 16'd2023, 16'd0);
        send_date_op(ACT_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd0);
        send_date_op(ACT_SET, 5'd10, 4'd0, 16'd2023, 16'd0);
        send_date_op(ACT_SET, 5'd31, 4'd13, 16'd2023, 16'd0);
        send_date_op(ACT_SET, 5'd31, 4'd15, 16'd0, 16'd0);
        // year wrap and largest step
        send_date_op(ACT_SET, 5'd31, MONTHS, 16'hffff, 16'd0);
        send_date_op(ACT_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd1);
        send_date_op(ACT_ADVANCE, 5'd0, 4'd0, 16'd0, 16'hffff);
        // compare ordering
        send_date_op(ACT_SET, 5'd15, 4'd6, 16'd2023, 16'd0);
        send_date_op(ACT_COMPARE, 5'd15, 4'd6, 16'd2023, 16'd0);
        send_date_op(ACT_COMPARE, 5'd1, 4'd1, 16'd2024, 16'd0);
        send_date_op(ACT_COMPARE, 5'd31, 4'd12, 16'd2022, 16'd0);
        send_date_op(ACT_COMPARE, 5'd1, 4'd7, 16'd2023, 16'd0);
        send_date_op(ACT_COMPARE, 5'd14, 4'd6, 16'd2023, 16'd0);
        send_date_op(ACT_COMPARE, 5'd15, 4'd13, 16'd2023, 16'd0);
        send_date_op(ACT_NONE, 5'd0, 4'd0, 16'd0, 16'd0);
        wait_all_results();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (!hold_done && sent >= 90) begin
                // long receiver hold-off while the sender keeps pushing
                hold_done = 1'b1;
                hold_request = 1'b1;
                repeat (16) send_random_item();
            end else if (!drain_done && sent >= 180) begin
                drain_done = 1'b1;
                wait_all_results();
                sender_gap($urandom_range(1, 5));
                repeat (10) send_random_item();
            end else begin
                burst = $urandom_range(1, 12);
                repeat (burst) send_random_item();
                if ($urandom_range(3) != 0)
                    sender_gap($urandom_range(0, 6));
            end
        end

        wait_all_results();
        repeat (50) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
